// ----- design/generational_handle_allocator_macros.svh -----
// Assertion macros used by the allocator back end.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset.
`define GHA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// Condition in one cycle implies the consequence in the next.
`define GHA_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: assertion failed");
`else
`define GHA_ASSERT(lbl, clk, rst, prop)
`define GHA_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// ----- design/gha_pkg.sv -----
package gha_pkg;

   localparam int DEF_SLOTS    = 64;
   localparam int DEF_GEN_BITS = 16;

   localparam int OP_W     = 3;
   localparam int PIDX_W   = 6;
   localparam int PGEN_W   = 16;
   localparam int STATUS_W = 2;
   localparam int KCNT_W   = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int CHUNK_LANES = 8;
   localparam int LANE_SHIFT  = 3;

   localparam logic [OP_W-1:0] OP_SPAWN    = 3'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd1;
   localparam logic [OP_W-1:0] OP_KILL     = 3'd2;
   localparam logic [OP_W-1:0] OP_MARK     = 3'd3;
   localparam logic [OP_W-1:0] OP_SWEEP    = 3'd4;
   localparam logic [OP_W-1:0] OP_KILL_ALL = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [2:0] {
      CMD_SPAWN,
      CMD_LOOKUP,
      CMD_KILL,
      CMD_MARK,
      CMD_SWEEP,
      CMD_KILL_ALL,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [PIDX_W-1:0]         index;
      logic [PGEN_W-1:0]         generation;
      logic                      index_ok;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } beat_type;

endpackage

// ----- design/generational_handle_allocator.sv -----
// Channel   Ports                                         Handshake
// command   req_op, req_handle_index, req_handle_generation  start & !busy
// result    rsp_status, rsp_slot_index, rsp_slot_generation,
//           rsp_slot_alive, rsp_killed_count              rsp_strobe, one cycle
//
// Spawn, lookup, kill and mark: dequeue with the generation memory read,
// then compare and write back; the result strobes in the following cycle.
// An unused op returns its result from the dequeue without table update.
// Sweep and kill-all walk the slots below the high-water mark, 8 slots a cycle.
// A two-entry command queue holds accepted beats; busy is high while it is full.
// Reset empties the table at once (high-water mark 1); no clearing pass.
// The receiver cannot stall; every result is presented for one cycle.
module generational_handle_allocator import gha_pkg::*; #(
   parameter int SLOTS    = DEF_SLOTS,
   parameter int GEN_BITS = DEF_GEN_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_op,
   input  logic [PIDX_W-1:0]   req_handle_index,
   input  logic [PGEN_W-1:0]   req_handle_generation,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PIDX_W-1:0]   rsp_slot_index,
   output logic [PGEN_W-1:0]   rsp_slot_generation,
   output logic                rsp_slot_alive,
   output logic [KCNT_W-1:0]   rsp_killed_count
);

   beat_type push;
   beat_type head;
   logic     pop;
   logic     full;

   assign busy = full;

   gha_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .start                 (start),
      .busy                  (full),
      .req_op                (req_op),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .push                  (push)
   );

   gha_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (full),
      .head  (head)
   );

   gha_back #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .pop                 (pop),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_slot_generation (rsp_slot_generation),
      .rsp_slot_alive      (rsp_slot_alive),
      .rsp_killed_count    (rsp_killed_count)
   );

endmodule

// ----- design/gha_front.sv -----
module gha_front import gha_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic              start,
   input  logic              busy,
   input  logic [OP_W-1:0]   req_op,
   input  logic [PIDX_W-1:0] req_handle_index,
   input  logic [PGEN_W-1:0] req_handle_generation,
   output beat_type          push
);

   cmd_type cmd;

   always_comb begin
      cmd            = '0;
      cmd.index      = req_handle_index;
      cmd.generation = req_handle_generation;
      // slot 0 is reserved; indexes past the table never match
      cmd.index_ok   = (req_handle_index != '0) && (int'(req_handle_index) < SLOTS);
      unique case (req_op)
         OP_SPAWN:    cmd.kind = CMD_SPAWN;
         OP_LOOKUP:   cmd.kind = CMD_LOOKUP;
         OP_KILL:     cmd.kind = CMD_KILL;
         OP_MARK:     cmd.kind = CMD_MARK;
         OP_SWEEP:    cmd.kind = CMD_SWEEP;
         OP_KILL_ALL: cmd.kind = CMD_KILL_ALL;
         default:     cmd.kind = CMD_NOP;
      endcase
   end

   assign push.valid = start && !busy;
   assign push.cmd   = cmd;

endmodule

// ----- design/gha_queue.sv -----
module gha_queue import gha_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  beat_type push,
   input  logic     pop,
   output logic     full,
   output beat_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ----- design/gha_back.sv -----
`include "generational_handle_allocator_macros.svh"

module gha_back import gha_pkg::*; #(
   parameter int SLOTS    = DEF_SLOTS,
   parameter int GEN_BITS = DEF_GEN_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  beat_type            head,
   output logic                pop,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PIDX_W-1:0]   rsp_slot_index,
   output logic [PGEN_W-1:0]   rsp_slot_generation,
   output logic                rsp_slot_alive,
   output logic [KCNT_W-1:0]   rsp_killed_count
);

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int HW_W    = $clog2(SLOTS + 1);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int CHUNKS  = (SLOTS + CHUNK_LANES - 1) / CHUNK_LANES;
   localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int LCNT_W  = $clog2(CHUNK_LANES + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_WALK = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic                hit_ff, hit_in;
   logic [CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic [CNT_W-1:0]    killed_ff, killed_in;
   logic [HW_W-1:0]     hw_ff, hw_in;
   logic [SLOTS-1:0]    alive_ff, alive_in;
   logic [SLOTS-1:0]    marked_ff, marked_in;
   logic [GEN_BITS-1:0] rd_ff;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PIDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [PGEN_W-1:0]   rsp_gen_ff, rsp_gen_in;
   logic                rsp_alive_ff, rsp_alive_in;
   logic [KCNT_W-1:0]   rsp_killed_ff, rsp_killed_in;

   logic [GEN_BITS-1:0] gen_mem [SLOTS];
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [GEN_BITS-1:0] wr_data;

   logic [SLOTS-1:0]    in_range, free_vec, low_vec, chunk_sel, hit_vec;
   logic [IDX_W-1:0]    found;
   logic                any_free;
   logic [CHUNKS*CHUNK_LANES-1:0] hit_pad;
   logic [CHUNK_LANES-1:0]        lane_hits;
   logic [LCNT_W-1:0]   lane_count;
   logic [HW_W-1:0]     last_chunk;
   logic                spawn_ok;
   logic                spawn_fire;
   logic                handle_ok;

   logic [GEN_BITS+PGEN_W-1:0] cmd_gen_ext;
   logic [GEN_BITS-1:0]        cmd_gen;
   logic [IDX_W+PIDX_W-1:0]    cmd_idx_ext;
   logic [IDX_W-1:0]           cmd_idx;
   logic [IDX_W+PIDX_W-1:0]    slot_out_ext;
   logic [GEN_BITS+PGEN_W-1:0] gen_out_ext;
   logic [GEN_BITS-1:0]        gen_out;
   logic [CNT_W+KCNT_W-1:0]    killed_out_ext;

   // resize handle fields to the table's widths
   assign cmd_gen_ext = {{GEN_BITS{1'b0}}, cmd_ff.generation};
   assign cmd_gen     = cmd_gen_ext[GEN_BITS-1:0];
   assign cmd_idx_ext = {{IDX_W{1'b0}}, cmd_ff.index};
   assign cmd_idx     = cmd_idx_ext[IDX_W-1:0];

   // lowest dead slot below the high-water mark
   always_comb begin
      found = '0;
      for (int j = 0; j < SLOTS; j++) begin
         in_range[j]  = (j != 0) && (HW_W'(j) < hw_ff);
         chunk_sel[j] = (CHUNK_W'(j >> LANE_SHIFT) == chunk_ff);
      end
      free_vec = ~alive_ff & in_range;
      low_vec  = free_vec & (~free_vec + SLOTS'(1));
      any_free = |free_vec;
      for (int j = 0; j < SLOTS; j++) begin
         if (low_vec[j]) begin
            found = found | IDX_W'(j);
         end
      end
   end

   // one chunk of lanes per cycle for sweep and kill-all
   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         hit_vec[j] = in_range[j] && chunk_sel[j] && alive_ff[j] &&
                      ((cmd_ff.kind == CMD_KILL_ALL) || marked_ff[j]);
      end
      hit_pad    = (CHUNKS*CHUNK_LANES)'(hit_vec);
      lane_hits  = hit_pad[chunk_ff*CHUNK_LANES +: CHUNK_LANES];
      lane_count = '0;
      for (int k = 0; k < CHUNK_LANES; k++) begin
         lane_count = lane_count + LCNT_W'(lane_hits[k]);
      end
      last_chunk = (hw_ff - HW_W'(1)) >> LANE_SHIFT;
   end

   assign spawn_ok   = hit_ff || (hw_ff < HW_W'(SLOTS));
   assign spawn_fire = (state_ff == ST_EXEC) && (cmd_ff.kind == CMD_SPAWN) && spawn_ok;
   assign handle_ok  = cmd_ff.index_ok && (HW_W'(cmd_idx) < hw_ff) && (rd_ff == cmd_gen);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      chunk_in      = chunk_ff;
      killed_in     = killed_ff;
      hw_in         = hw_ff;
      alive_in      = alive_ff;
      marked_in     = marked_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_data       = '0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_gen_in    = rsp_gen_ff;
      rsp_alive_in  = rsp_alive_ff;
      rsp_killed_in = rsp_killed_ff;
      slot_out_ext  = '0;
      gen_out       = '0;
      gen_out_ext   = '0;
      killed_out_ext = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               cmd_in  = head.cmd;
               hit_in  = any_free;
               slot_in = any_free ? found : hw_ff[IDX_W-1:0];
               chunk_in  = '0;
               killed_in = '0;
               rd_en   = 1'b1;
               rd_addr = (head.cmd.kind == CMD_SPAWN) ? slot_in :
                         IDX_W'({{IDX_W{1'b0}}, head.cmd.index});
               case (head.cmd.kind)
                  CMD_SWEEP, CMD_KILL_ALL: state_in = ST_WALK;
                  CMD_NOP: begin
                     // unused op: all-zero result, no table update
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_index_in  = '0;
                     rsp_gen_in    = '0;
                     rsp_alive_in  = 1'b0;
                     rsp_killed_in = '0;
                  end
                  default: state_in = ST_EXEC;
               endcase
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_killed_in = '0;
            rsp_alive_in  = 1'b0;
            if (cmd_ff.kind == CMD_SPAWN) begin
               if (spawn_ok) begin
                  wr_en   = 1'b1;
                  wr_data = hit_ff ? rd_ff + GEN_BITS'(1) : '0;
                  if (!hit_ff) begin
                     hw_in = hw_ff + HW_W'(1);
                  end
                  alive_in[slot_ff]  = 1'b1;
                  marked_in[slot_ff] = 1'b0;
                  gen_out = wr_data;
                  slot_out_ext  = {{PIDX_W{1'b0}}, slot_ff};
                  rsp_status_in = STATUS_OK;
                  rsp_alive_in  = 1'b1;
               end else begin
                  rsp_status_in = STATUS_FULL;
               end
            end else if (handle_ok) begin
               gen_out       = rd_ff;
               slot_out_ext  = {{PIDX_W{1'b0}}, cmd_idx};
               rsp_status_in = STATUS_OK;
               case (cmd_ff.kind)
                  CMD_LOOKUP: rsp_alive_in = alive_ff[cmd_idx];
                  CMD_KILL:   alive_in[cmd_idx] = 1'b0;
                  CMD_MARK:   marked_in[cmd_idx] = 1'b1;
                  default:    ;
               endcase
            end else begin
               rsp_status_in = STATUS_NOT_FOUND;
            end
            gen_out_ext  = {{PGEN_W{1'b0}}, gen_out};
            rsp_index_in = slot_out_ext[PIDX_W-1:0];
            rsp_gen_in   = gen_out_ext[PGEN_W-1:0];
         end
         ST_WALK: begin
            alive_in  = alive_ff & ~hit_vec;
            marked_in = (cmd_ff.kind == CMD_KILL_ALL) ?
                        (marked_ff & ~(in_range & chunk_sel)) : (marked_ff & ~hit_vec);
            killed_in = killed_ff + CNT_W'(lane_count);
            chunk_in  = chunk_ff + CHUNK_W'(1);
            if (HW_W'(chunk_ff) == last_chunk) begin
               state_in       = ST_IDLE;
               killed_out_ext = {{KCNT_W{1'b0}}, killed_in};
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_index_in   = '0;
               rsp_gen_in     = '0;
               rsp_alive_in   = 1'b0;
               rsp_killed_in  = killed_out_ext[KCNT_W-1:0];
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hw_ff         <= HW_W'(1);
         alive_ff      <= '0;
         marked_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hw_ff         <= hw_in;
         alive_ff      <= alive_in;
         marked_ff     <= marked_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      chunk_ff      <= chunk_in;
      killed_ff     <= killed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_killed_ff <= rsp_killed_in;
   end

   // generation store: one read or one write per cycle, read data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= gen_mem[rd_addr];
      end
      if (wr_en) begin
         gen_mem[slot_ff] <= wr_data;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_index_ff;
   assign rsp_slot_generation = rsp_gen_ff;
   assign rsp_slot_alive      = rsp_alive_ff;
   assign rsp_killed_count    = rsp_killed_ff;

   `GHA_ASSERT(a_hw_range, clock, reset, (hw_ff >= HW_W'(1)) && (hw_ff <= HW_W'(SLOTS)))
   `GHA_ASSERT(a_slot0_idle, clock, reset, !alive_ff[0] && !marked_ff[0])
   `GHA_ASSERT(a_alive_in_range, clock, reset, (alive_ff & ~in_range) == '0)
   `GHA_ASSERT_NEXT(a_spawn_alive, clock, reset, spawn_fire, alive_ff[$past(slot_ff)] && rsp_strobe_ff)

endmodule
